/* rtl/core/bpcr_pkg.sv */
package bpcr_pkg;

    // Field widths
    localparam int CW      = 20;   // coordinate and velocity width
    localparam int DW      = 21;   // difference of two coordinates
    localparam int RAD_W   = 16;
    localparam int RS_W    = 17;   // radius sum
    localparam int COEF_W  = 9;
    localparam int PUSH_W  = 9;
    localparam int SLOP_W  = 8;

    // Datapath widths
    localparam int DSQ_W   = 2 * DW;        // squared distance
    localparam int RSQ_W   = 2 * RS_W;      // squared radius sum
    localparam int ROOT_W  = DSQ_W / 2;     // distance
    localparam int REM_W   = ROOT_W + 2;    // square root remainder
    localparam int NORM_BITS = 16;
    localparam int QW      = NORM_BITS + 1; // normal magnitude, at most 1.0
    localparam int NUM_W   = DW + NORM_BITS;
    localparam int DREM_W  = ROOT_W + 1;    // divider remainder
    localparam int NV_W    = QW + 1;        // signed normal component
    localparam int PROD_W  = DW + NV_W;
    localparam int OVL_W   = ROOT_W + 1;
    localparam int S_W     = PROD_W + 1;    // closing speed
    localparam int K_W     = COEF_W + 1;
    localparam int JP_W    = S_W + K_W;
    localparam int IMP_SHIFT = 25;
    localparam int J_W     = JP_W - IMP_SHIFT;
    localparam int CP_W    = RS_W + PUSH_W;
    localparam int JX_W    = J_W + QW;
    localparam int SXP_W   = CP_W + QW;
    localparam int IX_W    = JX_W + 1 - NORM_BITS;
    localparam int SX_W    = SXP_W + 1 - IMP_SHIFT;
    localparam int VN_W    = IX_W + 2;

    // Stream widths
    localparam int IN_W    = 216;
    localparam int OUT_W   = 168;

    // Register reset values
    localparam logic [PUSH_W-1:0] PUSH_RESET = 9'd205;
    localparam logic [SLOP_W-1:0] SLOP_RESET = 8'd3;

    // Register indexes
    localparam logic CFG_PUSH = 1'b0;
    localparam logic CFG_SLOP = 1'b1;

    typedef struct packed {
        logic signed [CW-1:0] p1x;
        logic signed [CW-1:0] p1y;
        logic signed [CW-1:0] p2x;
        logic signed [CW-1:0] p2y;
        logic signed [CW-1:0] v1x;
        logic signed [CW-1:0] v1y;
        logic signed [CW-1:0] v2x;
        logic signed [CW-1:0] v2y;
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
        logic signed [DW-1:0] dvx;
        logic signed [DW-1:0] dvy;
        logic [RS_W-1:0]      rsum;
        logic [COEF_W-1:0]    emin;
        logic                 touching;
    } pair_t;

    function automatic logic signed [CW-1:0] sat_coord(input logic signed [VN_W-1:0] v);
        logic signed [VN_W-1:0] hi;
        logic signed [VN_W-1:0] lo;
        hi = {{(VN_W-CW+1){1'b0}}, {(CW-1){1'b1}}};
        lo = ~hi;
        if (v > hi)
        begin
            return hi[CW-1:0];
        end
        else if (v < lo)
        begin
            return lo[CW-1:0];
        end
        else
        begin
            return v[CW-1:0];
        end
    endfunction

endpackage

/* rtl/core/ball_pair_collision_resolver_unit.sv */
// Channel   Direction  Width  Contents
// s_axis    in         216    one ball pair per item
// m_axis    out        168    resolved pair per item
// cfg       in         9      push fraction (index 0), overlap slop (index 1)
//
// One item enters per cycle while the pipeline is not held. There are 3 front stages, 21 square
// root stages (one root bit each), 19 divider stages (a setup stage, 17
// quotient stages of one normal bit each and a sign stage) and 8 response
// stages ending in the output register.
// Reset clears the valid bits and loads the register reset values.
// The whole pipeline holds while a result waits at the output and
// m_axis_tready is low.
module ball_pair_collision_resolver_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // first_pos_x, first_pos_y, second_pos_x, second_pos_y, first_vel_x,
    // first_vel_y, second_vel_x, second_vel_y, first_radius, second_radius,
    // first_restitution, second_restitution, zero fill
    input  logic [bpcr_pkg::IN_W-1:0]       s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // new_first_vel_x, new_first_vel_y, new_second_vel_x, new_second_vel_y,
    // new_first_pos_x, new_first_pos_y, new_second_pos_x, new_second_pos_y,
    // touching, impulse_applied, zero fill
    output logic [bpcr_pkg::OUT_W-1:0]      m_axis_tdata,
    input  logic                            cfg_we,
    input  logic                            cfg_addr,
    input  logic [bpcr_pkg::PUSH_W-1:0]     cfg_wdata
);
    import bpcr_pkg::*;

    logic [PUSH_W-1:0] push_reg;
    logic [SLOP_W-1:0] slop_reg;
    logic              en;
    logic              out_valid;

    logic              fr_valid;
    pair_t             fr_pair;
    logic [DSQ_W-1:0]  fr_dsq;

    logic              sq_valid;
    pair_t             sq_pair;
    logic [ROOT_W-1:0] sq_dist;

    logic                   dv_valid;
    pair_t                  dv_pair;
    logic [ROOT_W-1:0]      dv_dist;
    logic signed [NV_W-1:0] dv_nx, dv_ny;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push_reg <= PUSH_RESET;
            slop_reg <= SLOP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_PUSH: push_reg <= cfg_wdata;
                CFG_SLOP: slop_reg <= cfg_wdata[SLOP_W-1:0];
                default:  push_reg <= push_reg;
            endcase
        end
    end

    assign en            = !out_valid || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = out_valid;

    bpcr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .in_data   (s_axis_tdata),
        .out_valid (fr_valid),
        .out_pair  (fr_pair),
        .out_dsq   (fr_dsq)
    );

    bpcr_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fr_valid),
        .in_pair   (fr_pair),
        .in_dsq    (fr_dsq),
        .out_valid (sq_valid),
        .out_pair  (sq_pair),
        .out_dist  (sq_dist)
    );

    bpcr_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .in_pair   (sq_pair),
        .in_dist   (sq_dist),
        .out_valid (dv_valid),
        .out_pair  (dv_pair),
        .out_dist  (dv_dist),
        .out_nx    (dv_nx),
        .out_ny    (dv_ny)
    );

    bpcr_resp u_resp (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (dv_valid),
        .in_pair   (dv_pair),
        .in_dist   (dv_dist),
        .in_nx     (dv_nx),
        .in_ny     (dv_ny),
        .push      (push_reg),
        .slop      (slop_reg),
        .out_valid (out_valid),
        .out_data  (m_axis_tdata)
    );

endmodule

/* rtl/core/bpcr_front.sv */
module bpcr_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic [bpcr_pkg::IN_W-1:0]      in_data,
    output logic                           out_valid,
    output bpcr_pkg::pair_t                out_pair,
    output logic [bpcr_pkg::DSQ_W-1:0]     out_dsq
);
    import bpcr_pkg::*;

    logic signed [CW-1:0] p1x, p1y, p2x, p2y, v1x, v1y, v2x, v2y;
    logic [RAD_W-1:0]     r1, r2;
    logic [COEF_W-1:0]    e1, e2;

    assign p1x = in_data[0*CW +: CW];
    assign p1y = in_data[1*CW +: CW];
    assign p2x = in_data[2*CW +: CW];
    assign p2y = in_data[3*CW +: CW];
    assign v1x = in_data[4*CW +: CW];
    assign v1y = in_data[5*CW +: CW];
    assign v2x = in_data[6*CW +: CW];
    assign v2y = in_data[7*CW +: CW];
    assign r1  = in_data[8*CW +: RAD_W];
    assign r2  = in_data[8*CW+RAD_W +: RAD_W];
    assign e1  = in_data[8*CW+2*RAD_W +: COEF_W];
    assign e2  = in_data[8*CW+2*RAD_W+COEF_W +: COEF_W];

    logic                     f1_vld_reg, f2_vld_reg, f3_vld_reg;
    pair_t                    f1_pair_reg, f2_pair_reg, f3_pair_reg;
    pair_t                    f1_pair_next, f3_pair_next;
    logic signed [DSQ_W-1:0]  dxsq_reg, dysq_reg;
    logic [RSQ_W-1:0]         rsq_reg;
    logic [DSQ_W-1:0]         dsq_reg, dsq_next;

    always_comb
    begin
        f1_pair_next          = '0;
        f1_pair_next.p1x      = p1x;
        f1_pair_next.p1y      = p1y;
        f1_pair_next.p2x      = p2x;
        f1_pair_next.p2y      = p2y;
        f1_pair_next.v1x      = v1x;
        f1_pair_next.v1y      = v1y;
        f1_pair_next.v2x      = v2x;
        f1_pair_next.v2y      = v2y;
        f1_pair_next.dx       = DW'(p2x) - DW'(p1x);
        f1_pair_next.dy       = DW'(p2y) - DW'(p1y);
        f1_pair_next.dvx      = DW'(v2x) - DW'(v1x);
        f1_pair_next.dvy      = DW'(v2y) - DW'(v1y);
        f1_pair_next.rsum     = {1'b0, r1} + {1'b0, r2};
        f1_pair_next.emin     = (e1 < e2) ? e1 : e2;
        f1_pair_next.touching = 1'b0;
    end

    always_comb
    begin
        dsq_next              = $unsigned(dxsq_reg) + $unsigned(dysq_reg);
        f3_pair_next          = f2_pair_reg;
        f3_pair_next.touching = (dsq_next <= DSQ_W'(rsq_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_vld_reg <= 1'b0;
            f2_vld_reg <= 1'b0;
            f3_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            f1_vld_reg <= in_valid;
            f2_vld_reg <= f1_vld_reg;
            f3_vld_reg <= f2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_pair_reg <= f1_pair_next;
            f2_pair_reg <= f1_pair_reg;
            dxsq_reg    <= f1_pair_reg.dx * f1_pair_reg.dx;
            dysq_reg    <= f1_pair_reg.dy * f1_pair_reg.dy;
            rsq_reg     <= f1_pair_reg.rsum * f1_pair_reg.rsum;
            f3_pair_reg <= f3_pair_next;
            dsq_reg     <= dsq_next;
        end
    end

    assign out_valid = f3_vld_reg;
    assign out_pair  = f3_pair_reg;
    assign out_dsq   = dsq_reg;

endmodule

/* rtl/core/bpcr_sqrt.sv */
module bpcr_sqrt (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_valid,
    input  bpcr_pkg::pair_t                in_pair,
    input  logic [bpcr_pkg::DSQ_W-1:0]     in_dsq,
    output logic                           out_valid,
    output bpcr_pkg::pair_t                out_pair,
    output logic [bpcr_pkg::ROOT_W-1:0]    out_dist
);
    import bpcr_pkg::*;

    logic              vld_reg  [ROOT_W];
    pair_t             pair_reg [ROOT_W];
    logic [DSQ_W-1:0]  dsq_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [REM_W-1:0]  rem_reg  [ROOT_W];

    logic              st_vld  [ROOT_W];
    pair_t             st_pair [ROOT_W];
    logic [DSQ_W-1:0]  st_dsq  [ROOT_W];
    logic [ROOT_W-1:0] st_root [ROOT_W];
    logic [REM_W-1:0]  st_rem  [ROOT_W];

    // One result bit per stage, two radicand bits shifted into the remainder.
    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_step
        localparam int K = ROOT_W - 1 - i;
        logic [REM_W+1:0] trial;
        logic [REM_W+1:0] test;

        if (i == 0)
        begin : g_first
            assign st_vld[i]  = in_valid;
            assign st_pair[i] = in_pair;
            assign st_dsq[i]  = in_dsq;
            assign st_root[i] = '0;
            assign st_rem[i]  = '0;
        end
        else
        begin : g_next
            assign st_vld[i]  = vld_reg[i-1];
            assign st_pair[i] = pair_reg[i-1];
            assign st_dsq[i]  = dsq_reg[i-1];
            assign st_root[i] = root_reg[i-1];
            assign st_rem[i]  = rem_reg[i-1];
        end

        assign trial = {st_rem[i], st_dsq[i][2*K+1 -: 2]};
        assign test  = (REM_W+2)'({st_root[i], 2'b01});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[i] <= st_vld[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pair_reg[i] <= st_pair[i];
                dsq_reg[i]  <= st_dsq[i];
                if (trial >= test)
                begin
                    rem_reg[i]  <= REM_W'(trial - test);
                    root_reg[i] <= {st_root[i][ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[i]  <= REM_W'(trial);
                    root_reg[i] <= {st_root[i][ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    assign out_valid = vld_reg[ROOT_W-1];
    assign out_pair  = pair_reg[ROOT_W-1];
    assign out_dist  = root_reg[ROOT_W-1];

endmodule

/* rtl/core/bpcr_div.sv */
module bpcr_div (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  bpcr_pkg::pair_t                      in_pair,
    input  logic [bpcr_pkg::ROOT_W-1:0]          in_dist,
    output logic                                 out_valid,
    output bpcr_pkg::pair_t                      out_pair,
    output logic [bpcr_pkg::ROOT_W-1:0]          out_dist,
    output logic signed [bpcr_pkg::NV_W-1:0]     out_nx,
    output logic signed [bpcr_pkg::NV_W-1:0]     out_ny
);
    import bpcr_pkg::*;

    // Setup stage: rounded numerator |d| * 2^16 + dist / 2 for both lanes.
    logic               pre_vld_reg;
    pair_t              pre_pair_reg;
    logic [ROOT_W-1:0]  pre_dist_reg;
    logic [DREM_W-1:0]  pre_rem_reg [2];
    logic [QW-1:0]      pre_low_reg [2];
    logic               pre_neg_reg [2];

    logic [DW-1:0]      mag [2];
    logic [NUM_W-1:0]   num [2];
    logic               neg [2];

    assign neg[0] = in_pair.dx[DW-1];
    assign neg[1] = in_pair.dy[DW-1];
    assign mag[0] = neg[0] ? DW'(-in_pair.dx) : DW'(in_pair.dx);
    assign mag[1] = neg[1] ? DW'(-in_pair.dy) : DW'(in_pair.dy);

    for (genvar l = 0; l < 2; l++)
    begin : g_num
        assign num[l] = {mag[l], {NORM_BITS{1'b0}}} + NUM_W'(in_dist >> 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            pre_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pre_pair_reg <= in_pair;
            pre_dist_reg <= in_dist;
            for (int l = 0; l < 2; l++)
            begin
                pre_rem_reg[l] <= DREM_W'(num[l] >> QW);
                pre_low_reg[l] <= num[l][QW-1:0];
                pre_neg_reg[l] <= neg[l];
            end
        end
    end

    // Restoring division, one quotient bit per stage.
    logic              vld_reg  [QW];
    pair_t             pair_reg [QW];
    logic [ROOT_W-1:0] dist_reg [QW];
    logic [DREM_W-1:0] rem_reg  [QW][2];
    logic [QW-1:0]     low_reg  [QW][2];
    logic [QW-1:0]     q_reg    [QW][2];
    logic              neg_reg  [QW][2];

    logic              st_vld  [QW];
    pair_t             st_pair [QW];
    logic [ROOT_W-1:0] st_dist [QW];
    logic [DREM_W-1:0] st_rem  [QW][2];
    logic [QW-1:0]     st_low  [QW][2];
    logic [QW-1:0]     st_q    [QW][2];
    logic              st_neg  [QW][2];

    for (genvar i = 0; i < QW; i++)
    begin : g_step
        if (i == 0)
        begin : g_first
            assign st_vld[i]  = pre_vld_reg;
            assign st_pair[i] = pre_pair_reg;
            assign st_dist[i] = pre_dist_reg;
        end
        else
        begin : g_next
            assign st_vld[i]  = vld_reg[i-1];
            assign st_pair[i] = pair_reg[i-1];
            assign st_dist[i] = dist_reg[i-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[i] <= st_vld[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pair_reg[i] <= st_pair[i];
                dist_reg[i] <= st_dist[i];
            end
        end

        for (genvar l = 0; l < 2; l++)
        begin : g_lane
            logic [DREM_W-1:0] trial;

            if (i == 0)
            begin : g_first
                assign st_rem[i][l] = pre_rem_reg[l];
                assign st_low[i][l] = pre_low_reg[l];
                assign st_q[i][l]   = '0;
                assign st_neg[i][l] = pre_neg_reg[l];
            end
            else
            begin : g_next
                assign st_rem[i][l] = rem_reg[i-1][l];
                assign st_low[i][l] = low_reg[i-1][l];
                assign st_q[i][l]   = q_reg[i-1][l];
                assign st_neg[i][l] = neg_reg[i-1][l];
            end

            assign trial = {st_rem[i][l][DREM_W-2:0], st_low[i][l][QW-1-i]};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    low_reg[i][l] <= st_low[i][l];
                    neg_reg[i][l] <= st_neg[i][l];
                    if (trial >= {1'b0, st_dist[i]})
                    begin
                        rem_reg[i][l] <= trial - {1'b0, st_dist[i]};
                        q_reg[i][l]   <= {st_q[i][l][QW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[i][l] <= trial;
                        q_reg[i][l]   <= {st_q[i][l][QW-2:0], 1'b0};
                    end
                end
            end
        end
    end

    // Sign stage.
    logic                    fin_vld_reg;
    pair_t                   fin_pair_reg;
    logic [ROOT_W-1:0]       fin_dist_reg;
    logic signed [NV_W-1:0]  fin_n_reg [2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            fin_vld_reg <= vld_reg[QW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fin_pair_reg <= pair_reg[QW-1];
            fin_dist_reg <= dist_reg[QW-1];
            for (int l = 0; l < 2; l++)
            begin
                fin_n_reg[l] <= neg_reg[QW-1][l] ? -$signed({1'b0, q_reg[QW-1][l]})
                                                 :  $signed({1'b0, q_reg[QW-1][l]});
            end
        end
    end

    assign out_valid = fin_vld_reg;
    assign out_pair  = fin_pair_reg;
    assign out_dist  = fin_dist_reg;
    assign out_nx    = fin_n_reg[0];
    assign out_ny    = fin_n_reg[1];

endmodule

/* rtl/core/bpcr_resp.sv */
module bpcr_resp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  bpcr_pkg::pair_t                      in_pair,
    input  logic [bpcr_pkg::ROOT_W-1:0]          in_dist,
    input  logic signed [bpcr_pkg::NV_W-1:0]     in_nx,
    input  logic signed [bpcr_pkg::NV_W-1:0]     in_ny,
    input  logic [bpcr_pkg::PUSH_W-1:0]          push,
    input  logic [bpcr_pkg::SLOP_W-1:0]          slop,
    output logic                                 out_valid,
    output logic [bpcr_pkg::OUT_W-1:0]           out_data
);
    import bpcr_pkg::*;

    // Stage 1: speed products along the normal, overlap.
    logic                     r1_vld_reg;
    pair_t                    r1_pair_reg;
    logic signed [PROD_W-1:0] r1_px_reg, r1_py_reg;
    logic signed [OVL_W-1:0]  r1_ovl_reg;
    logic                     r1_nz_reg;
    logic signed [NV_W-1:0]   r1_nx_reg, r1_ny_reg;

    // Stage 2: closing speed, overlap beyond the slop.
    logic                     r2_vld_reg;
    pair_t                    r2_pair_reg;
    logic signed [S_W-1:0]    r2_s_reg;
    logic                     r2_ovlpos_reg;
    logic [RS_W-1:0]          r2_c_reg;
    logic                     r2_nz_reg;
    logic signed [NV_W-1:0]   r2_nx_reg, r2_ny_reg;

    // Stage 3: impulse decision, coefficient, push amount.
    logic                     r3_vld_reg;
    pair_t                    r3_pair_reg;
    logic                     r3_applied_reg;
    logic                     r3_ovlpos_reg;
    logic [S_W-1:0]           r3_negs_reg;
    logic [K_W-1:0]           r3_k_reg;
    logic [CP_W-1:0]          r3_cp_reg;
    logic signed [NV_W-1:0]   r3_nx_reg, r3_ny_reg;

    // Stage 4: scaled impulse.
    logic                     r4_vld_reg;
    pair_t                    r4_pair_reg;
    logic                     r4_applied_reg;
    logic                     r4_ovlpos_reg;
    logic [JP_W-1:0]          r4_jp_reg;
    logic [CP_W-1:0]          r4_cp_reg;
    logic signed [NV_W-1:0]   r4_nx_reg, r4_ny_reg;

    // Stage 5: rounded impulse, normal magnitudes.
    logic                     r5_vld_reg;
    pair_t                    r5_pair_reg;
    logic                     r5_applied_reg;
    logic                     r5_ovlpos_reg;
    logic [J_W-1:0]           r5_j_reg;
    logic [CP_W-1:0]          r5_cp_reg;
    logic [QW-1:0]            r5_nxm_reg, r5_nym_reg;
    logic                     r5_nxneg_reg, r5_nyneg_reg;

    // Stage 6: projections onto the normal.
    logic                     r6_vld_reg;
    pair_t                    r6_pair_reg;
    logic                     r6_applied_reg;
    logic                     r6_ovlpos_reg;
    logic [JX_W-1:0]          r6_jx_reg, r6_jy_reg;
    logic [SXP_W-1:0]         r6_sx_reg, r6_sy_reg;
    logic                     r6_nxneg_reg, r6_nyneg_reg;

    // Stage 7: rounded, gated corrections.
    logic                     r7_vld_reg;
    pair_t                    r7_pair_reg;
    logic                     r7_applied_reg;
    logic [IX_W-1:0]          r7_ix_reg, r7_iy_reg;
    logic [SX_W-1:0]          r7_sx_reg, r7_sy_reg;
    logic                     r7_nxneg_reg, r7_nyneg_reg;

    // Stage 8: output register.
    logic                     r8_vld_reg;
    logic [OUT_W-1:0]         r8_data_reg, r8_data_next;

    logic signed [OVL_W-1:0]  ovl_next;
    logic [JP_W-1:0]          jp_round;
    logic [JX_W:0]            jx_round, jy_round;
    logic [SXP_W:0]           sx_round, sy_round;

    assign ovl_next = $signed({{(OVL_W-RS_W){1'b0}}, in_pair.rsum})
                    - $signed({1'b0, in_dist});
    assign jp_round = r4_jp_reg + (JP_W'(1) << (IMP_SHIFT - 1));
    assign jx_round = {1'b0, r6_jx_reg} + ((JX_W+1)'(1) << (NORM_BITS - 1));
    assign jy_round = {1'b0, r6_jy_reg} + ((JX_W+1)'(1) << (NORM_BITS - 1));
    assign sx_round = {1'b0, r6_sx_reg} + ((SXP_W+1)'(1) << (IMP_SHIFT - 1));
    assign sy_round = {1'b0, r6_sy_reg} + ((SXP_W+1)'(1) << (IMP_SHIFT - 1));

    always_comb
    begin
        logic signed [VN_W-1:0] v1x, v1y, v2x, v2y, p1x, p1y, p2x, p2y;
        logic [VN_W-1:0]        ix, iy, sx, sy;
        ix  = VN_W'(r7_ix_reg);
        iy  = VN_W'(r7_iy_reg);
        sx  = VN_W'(r7_sx_reg);
        sy  = VN_W'(r7_sy_reg);
        // The first ball moves against the normal, the second along it.
        v1x = r7_nxneg_reg ? VN_W'(r7_pair_reg.v1x) + ix : VN_W'(r7_pair_reg.v1x) - ix;
        v2x = r7_nxneg_reg ? VN_W'(r7_pair_reg.v2x) - ix : VN_W'(r7_pair_reg.v2x) + ix;
        v1y = r7_nyneg_reg ? VN_W'(r7_pair_reg.v1y) + iy : VN_W'(r7_pair_reg.v1y) - iy;
        v2y = r7_nyneg_reg ? VN_W'(r7_pair_reg.v2y) - iy : VN_W'(r7_pair_reg.v2y) + iy;
        p1x = r7_nxneg_reg ? VN_W'(r7_pair_reg.p1x) + sx : VN_W'(r7_pair_reg.p1x) - sx;
        p2x = r7_nxneg_reg ? VN_W'(r7_pair_reg.p2x) - sx : VN_W'(r7_pair_reg.p2x) + sx;
        p1y = r7_nyneg_reg ? VN_W'(r7_pair_reg.p1y) + sy : VN_W'(r7_pair_reg.p1y) - sy;
        p2y = r7_nyneg_reg ? VN_W'(r7_pair_reg.p2y) - sy : VN_W'(r7_pair_reg.p2y) + sy;
        r8_data_next = {6'b0, r7_applied_reg, r7_pair_reg.touching,
                        sat_coord(p2y), sat_coord(p2x), sat_coord(p1y), sat_coord(p1x),
                        sat_coord(v2y), sat_coord(v2x), sat_coord(v1y), sat_coord(v1x)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r1_vld_reg <= 1'b0;
            r2_vld_reg <= 1'b0;
            r3_vld_reg <= 1'b0;
            r4_vld_reg <= 1'b0;
            r5_vld_reg <= 1'b0;
            r6_vld_reg <= 1'b0;
            r7_vld_reg <= 1'b0;
            r8_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            r1_vld_reg <= in_valid;
            r2_vld_reg <= r1_vld_reg;
            r3_vld_reg <= r2_vld_reg;
            r4_vld_reg <= r3_vld_reg;
            r5_vld_reg <= r4_vld_reg;
            r6_vld_reg <= r5_vld_reg;
            r7_vld_reg <= r6_vld_reg;
            r8_vld_reg <= r7_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r1_pair_reg <= in_pair;
            r1_px_reg   <= in_pair.dvx * in_nx;
            r1_py_reg   <= in_pair.dvy * in_ny;
            r1_ovl_reg  <= ovl_next;
            r1_nz_reg   <= (in_dist != '0);
            r1_nx_reg   <= in_nx;
            r1_ny_reg   <= in_ny;

            r2_pair_reg   <= r1_pair_reg;
            r2_s_reg      <= S_W'(r1_px_reg) + S_W'(r1_py_reg);
            r2_ovlpos_reg <= (r1_ovl_reg > $signed(OVL_W'(0)));
            if (r1_ovl_reg > $signed({{(OVL_W-SLOP_W){1'b0}}, slop}))
            begin
                r2_c_reg <= RS_W'(r1_ovl_reg - $signed({{(OVL_W-SLOP_W){1'b0}}, slop}));
            end
            else
            begin
                r2_c_reg <= '0;
            end
            r2_nz_reg <= r1_nz_reg;
            r2_nx_reg <= r1_nx_reg;
            r2_ny_reg <= r1_ny_reg;

            r3_pair_reg    <= r2_pair_reg;
            r3_applied_reg <= r2_nz_reg && (r2_s_reg[S_W-1] || (r2_s_reg == '0));
            r3_ovlpos_reg  <= r2_ovlpos_reg;
            r3_negs_reg    <= $unsigned(-r2_s_reg);
            r3_k_reg       <= {1'b0, r2_pair_reg.emin} + K_W'(256);
            r3_cp_reg      <= r2_c_reg * push;
            r3_nx_reg      <= r2_nx_reg;
            r3_ny_reg      <= r2_ny_reg;

            r4_pair_reg    <= r3_pair_reg;
            r4_applied_reg <= r3_applied_reg;
            r4_ovlpos_reg  <= r3_ovlpos_reg;
            r4_jp_reg      <= r3_negs_reg * r3_k_reg;
            r4_cp_reg      <= r3_cp_reg;
            r4_nx_reg      <= r3_nx_reg;
            r4_ny_reg      <= r3_ny_reg;

            r5_pair_reg    <= r4_pair_reg;
            r5_applied_reg <= r4_applied_reg;
            r5_ovlpos_reg  <= r4_ovlpos_reg;
            r5_j_reg       <= jp_round[JP_W-1:IMP_SHIFT];
            r5_cp_reg      <= r4_cp_reg;
            r5_nxneg_reg   <= r4_nx_reg[NV_W-1];
            r5_nyneg_reg   <= r4_ny_reg[NV_W-1];
            r5_nxm_reg     <= r4_nx_reg[NV_W-1] ? QW'(-r4_nx_reg) : QW'(r4_nx_reg);
            r5_nym_reg     <= r4_ny_reg[NV_W-1] ? QW'(-r4_ny_reg) : QW'(r4_ny_reg);

            r6_pair_reg    <= r5_pair_reg;
            r6_applied_reg <= r5_applied_reg;
            r6_ovlpos_reg  <= r5_ovlpos_reg;
            r6_jx_reg      <= r5_j_reg * r5_nxm_reg;
            r6_jy_reg      <= r5_j_reg * r5_nym_reg;
            r6_sx_reg      <= r5_cp_reg * r5_nxm_reg;
            r6_sy_reg      <= r5_cp_reg * r5_nym_reg;
            r6_nxneg_reg   <= r5_nxneg_reg;
            r6_nyneg_reg   <= r5_nyneg_reg;

            r7_pair_reg    <= r6_pair_reg;
            r7_applied_reg <= r6_applied_reg;
            r7_nxneg_reg   <= r6_nxneg_reg;
            r7_nyneg_reg   <= r6_nyneg_reg;
            // Separating pairs and pairs on one centre pass through unchanged.
            r7_ix_reg <= r6_applied_reg ? jx_round[NORM_BITS +: IX_W] : '0;
            r7_iy_reg <= r6_applied_reg ? jy_round[NORM_BITS +: IX_W] : '0;
            r7_sx_reg <= (r6_applied_reg && r6_ovlpos_reg) ? sx_round[IMP_SHIFT +: SX_W] : '0;
            r7_sy_reg <= (r6_applied_reg && r6_ovlpos_reg) ? sy_round[IMP_SHIFT +: SX_W] : '0;

            r8_data_reg <= r8_data_next;
        end
    end

    assign out_valid = r8_vld_reg;
    assign out_data  = r8_data_reg;

endmodule
